// File: rtl/core/lqr_msc_pkg.sv
// shared constants, types and codes for the lqr plant step unit
package lqr_msc_pkg;

    localparam int STATE_DIM_DEF   = 4;
    localparam int MAX_REWARDS_DEF = 4;
    localparam int NUM_COMP        = 4;
    localparam int COMP_W          = 16;
    localparam int EPS_W           = 17;
    localparam int DIM_REG_W       = 3;
    localparam int NREW_REG_W      = 3;
    localparam int CFG_DATA_W      = 17;
    localparam int CFG_IDX_W       = 2;
    localparam int REWARD_W        = 35;
    localparam int INDEX_W         = 2;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [EPS_W-1:0] ONE_Q16 = 17'h10000;

    // operation codes
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NREW = 2'd2;

    typedef logic signed [COMP_W-1:0] comp_t;

    // classified command word passed from front to back
    typedef struct packed {
        logic                              is_load;
        logic [NUM_COMP-1:0][COMP_W-1:0]   comp;
    } cmd_t;

    // raw configuration as written
    typedef struct packed {
        logic [EPS_W-1:0]      eps;
        logic [DIM_REG_W-1:0]  dim;
        logic [NREW_REG_W-1:0] nrew;
    } cfg_t;

endpackage

// File: rtl/core/lqr_msc_ifc.sv
// valid/ready channel interfaces for command and result words
interface lqr_msc_cmd_if
    import lqr_msc_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  operation;
    comp_t component_0;
    comp_t component_1;
    comp_t component_2;
    comp_t component_3;

    modport source (
        output valid, operation, component_0, component_1, component_2, component_3,
        input  ready
    );
    modport sink (
        input  valid, operation, component_0, component_1, component_2, component_3,
        output ready
    );
endinterface

interface lqr_msc_rsp_if
    import lqr_msc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [INDEX_W-1:0]         reward_index;
    logic signed [REWARD_W-1:0] reward;
    logic                       last;
    comp_t                      next_state_0;
    comp_t                      next_state_1;
    comp_t                      next_state_2;
    comp_t                      next_state_3;

    modport source (
        output valid, reward_index, reward, last,
               next_state_0, next_state_1, next_state_2, next_state_3,
        input  ready
    );
    modport sink (
        input  valid, reward_index, reward, last,
               next_state_0, next_state_1, next_state_2, next_state_3,
        output ready
    );
endinterface

// File: rtl/core/lqr_msc_front.sv
// front end: takes command words, classifies them and holds one for the queue
module lqr_msc_front
    import lqr_msc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lqr_msc_cmd_if.sink       cmd,
    output logic              push_valid,
    input  logic              push_ready,
    output cmd_t              push_data
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_reg;
    cmd_t hold_next;
    logic take;

    assign cmd.ready = !hold_valid_reg || push_ready;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        hold_next.is_load = (cmd.operation == OP_LOAD);
        hold_next.comp[0] = cmd.component_0;
        hold_next.comp[1] = cmd.component_1;
        hold_next.comp[2] = cmd.component_2;
        hold_next.comp[3] = cmd.component_3;
    end

    always_comb
    begin
        if (take)
            hold_valid_next = 1'b1;
        else if (push_ready)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            hold_reg <= hold_next;
    end

    assign push_valid = hold_valid_reg;
    assign push_data  = hold_reg;

endmodule

// File: rtl/core/lqr_msc_queue.sv
// short command queue between front and back
module lqr_msc_queue
    import lqr_msc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/core/lqr_msc_back.sv
// back end: plant state, cost pipeline and result sequencer
module lqr_msc_back
    import lqr_msc_pkg::*;
#(
    parameter int STATE_DIM   = STATE_DIM_DEF,
    parameter int MAX_REWARDS = MAX_REWARDS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  cmd_t          pop_data,
    lqr_msc_rsp_if.source rsp
);

    localparam int IDX_W  = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
    localparam int RI_W   = (MAX_REWARDS > 1) ? $clog2(MAX_REWARDS) : 1;
    localparam int SQ_W   = 31;
    localparam int PROD_W = 48;
    localparam int TERM_W = PROD_W - 16;
    localparam int DIFF_W = TERM_W + 2;
    localparam int SUM_W  = 33 + $clog2(STATE_DIM);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SQ    = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]              fsm_reg;
    logic [1:0]              fsm_next;

    comp_t                   state_reg [STATE_DIM];
    comp_t                   xw_reg [STATE_DIM];
    comp_t                   uw_reg [STATE_DIM];
    comp_t                   in_comp [STATE_DIM];
    comp_t                   step_next [STATE_DIM];
    logic signed [COMP_W:0]  wide_sum [STATE_DIM];

    logic [IDX_W-1:0]        dim_last;
    logic [RI_W-1:0]         nrew_last;
    logic [EPS_W-1:0]        eps_clamped;
    logic [IDX_W-1:0]        dim_last_reg;
    logic [RI_W-1:0]         nrew_last_reg;
    logic [EPS_W-1:0]        e_reg;
    logic                    one_mode_reg;

    logic [IDX_W-1:0]        j_reg;
    logic [RI_W-1:0]         i_reg;

    // pipeline stage 1: squares
    logic                    v1_reg;
    logic [IDX_W-1:0]        idx1_reg;
    logic [SQ_W-1:0]         xsq1_reg;
    logic [SQ_W-1:0]         usq1_reg;
    logic [COMP_W-1:0]       x_mag;
    logic [COMP_W-1:0]       u_mag;
    logic [2*COMP_W-1:0]     x_sq;
    logic [2*COMP_W-1:0]     u_sq;

    // pipeline stage 2: weighted products
    logic                    v2_reg;
    logic [IDX_W-1:0]        idx2_reg;
    logic [SQ_W-1:0]         xsq2_reg;
    logic [SQ_W-1:0]         usq2_reg;
    logic [PROD_W-1:0]       p2_reg;
    logic [PROD_W-1:0]       q2_reg;

    // stage 3: terms and accumulation
    logic [PROD_W-1:0]       a_full;
    logic [PROD_W-1:0]       d_full;
    logic [TERM_W-1:0]       a_term;
    logic [TERM_W-1:0]       b_term;
    logic [TERM_W-1:0]       c_term;
    logic [TERM_W-1:0]       d_term;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_reg [STATE_DIM];
    logic [SUM_W-1:0]        tsum_reg;
    logic [SUM_W-1:0]        tsum_next;

    // result
    logic signed [DIFF_W-1:0] diff_sel;
    logic signed [SUM_W:0]   total;
    logic signed [63:0]      neg_wide;
    logic                    out_free;
    logic                    pop_fire;
    logic                    rsp_valid_reg;
    logic [INDEX_W-1:0]      idx_reg;
    logic signed [REWARD_W-1:0] reward_reg;
    logic                    last_reg;

    // command components mapped onto state elements
    genvar g;
    generate
        for (g = 0; g < STATE_DIM; g++)
        begin : g_map
            if (g < NUM_COMP)
            begin : g_have
                assign in_comp[g] = comp_t'(pop_data.comp[g]);
            end
            else
            begin : g_none
                assign in_comp[g] = '0;
            end
        end
    endgenerate

    // next-state fields
    generate
        if (STATE_DIM > 0)
        begin : g_ns0
            assign rsp.next_state_0 = state_reg[0];
        end
        if (STATE_DIM > 1)
        begin : g_ns1
            assign rsp.next_state_1 = state_reg[1];
        end
        else
        begin : g_ns1z
            assign rsp.next_state_1 = '0;
        end
        if (STATE_DIM > 2)
        begin : g_ns2
            assign rsp.next_state_2 = state_reg[2];
        end
        else
        begin : g_ns2z
            assign rsp.next_state_2 = '0;
        end
        if (STATE_DIM > 3)
        begin : g_ns3
            assign rsp.next_state_3 = state_reg[3];
        end
        else
        begin : g_ns3z
            assign rsp.next_state_3 = '0;
        end
    endgenerate

    // clamp configuration
    always_comb
    begin
        if (cfg.dim == '0)
            dim_last = '0;
        else if (int'(cfg.dim) > STATE_DIM)
            dim_last = IDX_W'(STATE_DIM - 1);
        else
            dim_last = IDX_W'(cfg.dim - 3'd1);

        if (cfg.nrew == '0)
            nrew_last = '0;
        else if (int'(cfg.nrew) > MAX_REWARDS)
            nrew_last = RI_W'(MAX_REWARDS - 1);
        else
            nrew_last = RI_W'(cfg.nrew - 3'd1);

        eps_clamped = (cfg.eps > ONE_Q16) ? ONE_Q16 : cfg.eps;
    end

    // saturating state update on active elements
    always_comb
    begin
        for (int j = 0; j < STATE_DIM; j++)
        begin
            wide_sum[j] = (COMP_W+1)'(state_reg[j]) + (COMP_W+1)'(in_comp[j]);
            if (j > int'(dim_last))
                step_next[j] = state_reg[j];
            else if (wide_sum[j][COMP_W] != wide_sum[j][COMP_W-1])
                step_next[j] = wide_sum[j][COMP_W] ? comp_t'(16'sh8000) : comp_t'(16'sh7fff);
            else
                step_next[j] = wide_sum[j][COMP_W-1:0];
        end
    end

    // squares of the selected element
    always_comb
    begin
        x_mag = xw_reg[j_reg][COMP_W-1] ? COMP_W'(-xw_reg[j_reg]) : xw_reg[j_reg];
        u_mag = uw_reg[j_reg][COMP_W-1] ? COMP_W'(-uw_reg[j_reg]) : uw_reg[j_reg];
        x_sq  = x_mag * x_mag;
        u_sq  = u_mag * u_mag;
    end

    // weighted terms: (1-e)*s computed as (s<<16) - e*s
    always_comb
    begin
        if (one_mode_reg)
        begin
            a_term = TERM_W'(xsq2_reg);
            b_term = TERM_W'(xsq2_reg);
            c_term = TERM_W'(usq2_reg);
            d_term = TERM_W'(usq2_reg);
            a_full = '0;
            d_full = '0;
        end
        else
        begin
            a_full = PROD_W'({xsq2_reg, 16'h0000}) - p2_reg;
            d_full = PROD_W'({usq2_reg, 16'h0000}) - q2_reg;
            a_term = a_full[PROD_W-1:16];
            b_term = p2_reg[PROD_W-1:16];
            c_term = q2_reg[PROD_W-1:16];
            d_term = d_full[PROD_W-1:16];
        end
        diff_next = DIFF_W'(a_term) + DIFF_W'(c_term) - DIFF_W'(b_term) - DIFF_W'(d_term);
        tsum_next = tsum_reg + SUM_W'(b_term) + SUM_W'(d_term);
    end

    // reward of the current index
    always_comb
    begin
        diff_sel = '0;
        for (int k = 0; k < STATE_DIM; k++)
        begin
            if (int'(i_reg) == k && k <= int'(dim_last_reg))
                diff_sel = diff_reg[k];
        end
        total    = $signed({1'b0, tsum_reg}) + (SUM_W+1)'(diff_sel);
        neg_wide = -(64'(total));
    end

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign pop_ready = (fsm_reg == S_IDLE) && out_free;
    assign pop_fire  = pop_valid && pop_ready;

    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (pop_fire && !pop_data.is_load)
                    fsm_next = S_SQ;
            end
            S_SQ:
            begin
                if (j_reg == dim_last_reg)
                    fsm_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    fsm_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free && i_reg == nrew_last_reg)
                    fsm_next = S_IDLE;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // control and plant state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int j = 0; j < STATE_DIM; j++)
                state_reg[j] <= '0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            v1_reg  <= (fsm_reg == S_SQ);
            v2_reg  <= v1_reg;
            if (pop_fire)
            begin
                for (int j = 0; j < STATE_DIM; j++)
                begin
                    if (pop_data.is_load)
                    begin
                        if (j < NUM_COMP)
                            state_reg[j] <= in_comp[j];
                    end
                    else
                        state_reg[j] <= step_next[j];
                end
            end
            if ((pop_fire && pop_data.is_load) || (fsm_reg == S_EMIT && out_free))
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop_fire && !pop_data.is_load)
        begin
            for (int j = 0; j < STATE_DIM; j++)
            begin
                xw_reg[j] <= state_reg[j];
                uw_reg[j] <= in_comp[j];
            end
            dim_last_reg  <= dim_last;
            nrew_last_reg <= nrew_last;
            e_reg         <= eps_clamped;
            one_mode_reg  <= (dim_last == '0);
            j_reg         <= '0;
            tsum_reg      <= '0;
        end
        if (fsm_reg == S_SQ)
        begin
            j_reg    <= j_reg + 1'b1;
            idx1_reg <= j_reg;
            xsq1_reg <= x_sq[SQ_W-1:0];
            usq1_reg <= u_sq[SQ_W-1:0];
        end
        if (v1_reg)
        begin
            idx2_reg <= idx1_reg;
            xsq2_reg <= xsq1_reg;
            usq2_reg <= usq1_reg;
            p2_reg   <= PROD_W'(e_reg) * PROD_W'(xsq1_reg);
            q2_reg   <= PROD_W'(e_reg) * PROD_W'(usq1_reg);
        end
        if (v2_reg)
        begin
            diff_reg[idx2_reg] <= diff_next;
            tsum_reg           <= tsum_next;
        end
        if (fsm_reg == S_DRAIN)
            i_reg <= '0;
        if (pop_fire && pop_data.is_load)
        begin
            idx_reg    <= '0;
            reward_reg <= '0;
            last_reg   <= 1'b1;
        end
        else if (fsm_reg == S_EMIT && out_free)
        begin
            idx_reg    <= INDEX_W'(i_reg);
            reward_reg <= neg_wide[REWARD_W-1:0];
            last_reg   <= (i_reg == nrew_last_reg);
            i_reg      <= i_reg + 1'b1;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.reward_index = idx_reg;
    assign rsp.reward       = reward_reg;
    assign rsp.last         = last_reg;

endmodule

// File: rtl/core/lqr_plant_step_multi_cost_unit.sv
// top level of the lqr plant step unit with several quadratic costs
// path: a load word passes the front hold register, the queue slot and the back
//   result register; a step word also runs its elements through the square stage,
//   the product stage and the term stage. Loads sustain one word per cycle while
//   results are taken; a step holds the back end until its last reward is out
// reset: rst_n asynchronous, active low; clears the plant state to zero, eps to 0,
//   dimension to 4, reward count to 1, and empties the command queue
module lqr_plant_step_multi_cost_unit
    import lqr_msc_pkg::*;
#(
    parameter int STATE_DIM   = STATE_DIM_DEF,
    parameter int MAX_REWARDS = MAX_REWARDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lqr_msc_cmd_if.sink           cmd,
    lqr_msc_rsp_if.source         rsp,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    // configuration registers, to be written only while idle; the block does not enforce it
    logic [EPS_W-1:0]      eps_reg;
    logic [DIM_REG_W-1:0]  dim_reg;
    logic [NREW_REG_W-1:0] nrew_reg;
    cfg_t                  cfg;

    // front to queue
    logic push_valid;
    logic push_ready;
    cmd_t push_data;

    // queue to back
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= '0;
            dim_reg  <= DIM_REG_W'(4);
            nrew_reg <= NREW_REG_W'(1);
        end
        else if (wr_en)
        begin
            // writes past the register list are dropped
            unique case (wr_index)
                REG_EPS:  eps_reg  <= wr_data[EPS_W-1:0];
                REG_DIM:  dim_reg  <= wr_data[DIM_REG_W-1:0];
                REG_NREW: nrew_reg <= wr_data[NREW_REG_W-1:0];
                default:  ;
            endcase
        end
    end

    assign cfg.eps  = eps_reg;
    assign cfg.dim  = dim_reg;
    assign cfg.nrew = nrew_reg;

    // front end: registers the incoming word and tags load vs step
    lqr_msc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue so the front keeps taking words while the back works
    lqr_msc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back end: state update, element cost pipeline, one reward per cycle unless held
    lqr_msc_back #(
        .STATE_DIM   (STATE_DIM),
        .MAX_REWARDS (MAX_REWARDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

// File: rtl/core/lqr_msc_checker.sv
// port-level checks for the lqr plant step unit, bound to the top level
module lqr_msc_checker
    import lqr_msc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_last,
    input logic [INDEX_W-1:0]         rsp_index,
    input logic signed [REWARD_W-1:0] rsp_reward
);

    logic [3:0]         pend_reg;
    logic [3:0]         pend_next;
    logic [INDEX_W-1:0] expect_idx_reg;
    logic               cmd_take;
    logic               rsp_take;

    assign cmd_take = cmd_valid && cmd_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd_take && !(rsp_take && rsp_last))
            pend_next = pend_reg + 1'b1;
        else if (!cmd_take && rsp_take && rsp_last)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            expect_idx_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (rsp_take)
                expect_idx_reg <= rsp_last ? '0 : rsp_index + 1'b1;
        end
    end

    // a result word waits until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped before it was taken");

    // no result without an outstanding command word
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != '0)
        else $error("result word with no pending command");

    // reward indexes count up from zero within one command
    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_index == expect_idx_reg)
        else $error("reward index out of sequence");

    // a cost is never negative, so a reward is never positive
    a_reward_sign: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_reward[REWARD_W-1] || rsp_reward == '0))
        else $error("positive reward");

endmodule

bind lqr_plant_step_multi_cost_unit lqr_msc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_last   (rsp.last),
    .rsp_index  (rsp.reward_index),
    .rsp_reward (rsp.reward)
);

// File: sim/testbench.sv
// self-checking bench for the lqr plant step unit with several quadratic costs
module testbench;
    import lqr_msc_pkg::*;

    // one reward word as the block should emit it
    typedef struct packed {
        logic [INDEX_W-1:0]              index;
        logic signed [REWARD_W-1:0]      reward;
        logic                            last;
        logic [NUM_COMP-1:0][COMP_W-1:0] next_x;
    } reward_word_t;

    // directed stimulus row, components and states listed 3 down to 0
    typedef struct packed {
        logic                            op;
        logic [NUM_COMP-1:0][COMP_W-1:0] comp;
        logic                            typed;
        logic signed [REWARD_W-1:0]      reward;
        logic [NUM_COMP-1:0][COMP_W-1:0] next_x;
    } directed_row_t;

    // how both sides of the block idle during a phase
    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_t;

    localparam int QUIET_LIMIT      = 3000;
    localparam int HOLD_CYCLES      = 150;
    localparam int TAIL_CYCLES      = 24;
    localparam int RANDOM_PER_PHASE = 50;

    // typed rows run at reset settings: eps 0, dim 4, one reward, so
    // reward 0 = -(x0^2 + u1^2 + u2^2 + u3^2) in raw units of squared q7.8, 16 fraction bits
    localparam directed_row_t DIRECTED_ROWS [15] = '{
        // zero action on zero state
        '{OP_STEP, 64'h0000_0000_0000_0000, 1'b1, 35'sd0, 64'h0000_0000_0000_0000},
        // unit action, u0 carries no weight
        '{OP_STEP, 64'h0100_0100_0100_0100, 1'b1, -35'sd196608,
          64'h0100_0100_0100_0100},
        // load the positive extreme
        '{OP_LOAD, 64'h7fff_7fff_7fff_7fff, 1'b1, 35'sd0, 64'h7fff_7fff_7fff_7fff},
        // positive saturation on 0 and 1, cancel to -1 on 2 and 3
        '{OP_STEP, 64'h8000_8000_7fff_7fff, 1'b1, -35'sd4294836226,
          64'hffff_ffff_7fff_7fff},
        // load the negative extreme
        '{OP_LOAD, 64'h8000_8000_8000_8000, 1'b1, 35'sd0, 64'h8000_8000_8000_8000},
        // negative saturation everywhere, largest squares
        '{OP_STEP, 64'h8000_8000_8000_8000, 1'b1, -35'sd4294967296,
          64'h8000_8000_8000_8000},
        // alternating bit patterns
        '{OP_LOAD, 64'hff00_00ff_aaaa_5555, 1'b1, 35'sd0, 64'hff00_00ff_aaaa_5555},
        '{OP_STEP, 64'hffff_0001_edcb_1234, 1'b0, 35'sd0, 64'h0},
        '{OP_STEP, 64'h0f0f_f0f0_3c3c_c3c3, 1'b0, 35'sd0, 64'h0},
        // back to a zero state
        '{OP_LOAD, 64'h0000_0000_0000_0000, 1'b1, 35'sd0, 64'h0000_0000_0000_0000},
        // smallest and largest magnitudes mixed
        '{OP_STEP, 64'h8000_0000_0001_ffff, 1'b1, -35'sd1073741825,
          64'h8000_0000_0001_ffff},
        '{OP_STEP, 64'h7fff_7fff_ffff_0001, 1'b1, -35'sd2147352580,
          64'hffff_7fff_0000_0000},
        '{OP_LOAD, 64'he000_2000_c000_4000, 1'b1, 35'sd0, 64'he000_2000_c000_4000},
        '{OP_STEP, 64'h0080_ff80_0040_ffc0, 1'b0, 35'sd0, 64'h0},
        '{OP_STEP, 64'h0000_0000_0000_0000, 1'b0, 35'sd0, 64'h0}
    };

    // register settings per random phase: eps, dimension, reward count
    localparam cfg_t PHASE_SETTINGS [8] = '{
        '{17'd65536,  3'd4, 3'd4},   // eps exactly one, all rewards
        '{17'd131071, 3'd2, 3'd3},   // eps above one folds to one
        '{17'd0,      3'd1, 3'd4},   // single dimension, unit weights
        '{17'd32768,  3'd0, 3'd0},   // zero dimension and count fold to one
        '{17'd12345,  3'd7, 3'd7},   // both sizes above their maximum
        '{17'd1,      3'd3, 3'd2},   // top element inactive
        '{17'd65535,  3'd5, 3'd4},
        '{17'd0,      3'd4, 3'd1}    // back to reset values
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    lqr_msc_cmd_if cmd_ch ();
    lqr_msc_rsp_if rsp_ch ();

    lqr_plant_step_multi_cost_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // model of the plant state and the registers
    comp_t            plant_x [NUM_COMP];
    logic [EPS_W-1:0] reg_eps;
    logic [2:0]       reg_dim;
    logic [2:0]       reg_nrew;

    // reward words of the latest accepted command
    reward_word_t predicted_rewards [MAX_REWARDS_DEF];
    // reward words still owed by the block, oldest first
    reward_word_t awaited_rewards [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  hold_asked = 1'b0;
    int  hold_left  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // advance the plant model by one command word, return how many rewards it owes
    function automatic int plant_step_predict(input cmd_t w);
        longint unsigned x_sq [NUM_COMP];
        longint unsigned u_sq [NUM_COMP];
        longint unsigned e_w, ne_w, q_w, r_w, cost;
        longint          neg_cost;
        int              dim_eff, nrew_eff, sum_x;
        comp_t           u [NUM_COMP];
        for (int j = 0; j < NUM_COMP; j++)
            u[j] = w.comp[j];
        if (w.is_load == OP_LOAD)
        begin
            // load writes every element, active or not, and owes one zero reward
            for (int j = 0; j < NUM_COMP; j++)
                plant_x[j] = u[j];
            predicted_rewards[0]      = '0;
            predicted_rewards[0].last = 1'b1;
            for (int j = 0; j < NUM_COMP; j++)
                predicted_rewards[0].next_x[j] = plant_x[j];
            return 1;
        end
        // out-of-range sizes fold into 1..max, eps above one folds to one
        dim_eff  = (reg_dim == 0) ? 1 : (reg_dim > STATE_DIM_DEF) ? STATE_DIM_DEF : reg_dim;
        nrew_eff = (reg_nrew == 0) ? 1 :
                   (reg_nrew > MAX_REWARDS_DEF) ? MAX_REWARDS_DEF : reg_nrew;
        e_w  = (reg_eps > ONE_Q16) ? ONE_Q16 : reg_eps;
        ne_w = ONE_Q16 - e_w;
        // squares from the old state, then saturating update of active elements
        for (int j = 0; j < dim_eff; j++)
        begin
            x_sq[j] = longint'(plant_x[j]) * longint'(plant_x[j]);
            u_sq[j] = longint'(u[j]) * longint'(u[j]);
            sum_x   = plant_x[j] + u[j];
            if (sum_x > 32767)
                sum_x = 32767;
            if (sum_x < -32768)
                sum_x = -32768;
            plant_x[j] = sum_x[COMP_W-1:0];
        end
        for (int i = 0; i < nrew_eff; i++)
        begin
            cost = 0;
            for (int j = 0; j < dim_eff; j++)
            begin
                if (dim_eff == 1)
                begin
                    q_w = ONE_Q16;
                    r_w = ONE_Q16;
                end
                else if (i == j)
                begin
                    q_w = ne_w;
                    r_w = e_w;
                end
                else
                begin
                    q_w = e_w;
                    r_w = ne_w;
                end
                // each weighted term truncates before the sum
                cost += (q_w * x_sq[j]) >> 16;
                cost += (r_w * u_sq[j]) >> 16;
            end
            neg_cost = -longint'(cost);
            predicted_rewards[i]        = '0;
            predicted_rewards[i].index  = i[INDEX_W-1:0];
            predicted_rewards[i].reward = neg_cost[REWARD_W-1:0];
            predicted_rewards[i].last   = (i == nrew_eff - 1);
            for (int j = 0; j < NUM_COMP; j++)
                predicted_rewards[i].next_x[j] = plant_x[j];
        end
        return nrew_eff;
    endfunction

    // action or state element: often small, some full range, some extremes
    function automatic logic [COMP_W-1:0] random_component();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return COMP_W'($urandom_range(2047) - 1024);
        else if (pick < 70)
            return COMP_W'($urandom);
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic cmd_t random_command();
        cmd_t w;
        w.is_load = ($urandom_range(99) < 25) ? OP_LOAD : OP_STEP;
        for (int j = 0; j < NUM_COMP; j++)
            w.comp[j] = random_component();
        return w;
    endfunction

    function automatic void set_flow(input flow_t mode);
        sender_idle_pct    = (mode == FLOW_SENDER_IDLE) ? 65 : (mode == FLOW_BOTH) ? 15 : 0;
        receiver_stall_pct = (mode == FLOW_RECEIVER_STALL) ? 65 :
                             (mode == FLOW_BOTH) ? 15 : 0;
    endfunction

    // offer one command word, wait for its handshake, then queue what it owes
    task automatic send_command(input cmd_t w, input bit typed, input reward_word_t typed_word);
        int n;
        // valid only drops here, never in the step that raises it again
        if ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= w.is_load;
        cmd_ch.component_0 <= w.comp[0];
        cmd_ch.component_1 <= w.comp[1];
        cmd_ch.component_2 <= w.comp[2];
        cmd_ch.component_3 <= w.comp[3];
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        n = plant_step_predict(w);
        if (typed)
            awaited_rewards = {awaited_rewards, typed_word};
        else
            for (int i = 0; i < n; i++)
                awaited_rewards = {awaited_rewards, predicted_rewards[i]};
    endtask

    // stop offering and let every owed reward word come back
    task automatic wait_for_rewards();
        cmd_ch.valid <= 1'b0;
        while (awaited_rewards.size() != 0)
            @(posedge clk);
    endtask

    // back-to-back register writes while the block is idle
    task automatic apply_settings(input cfg_t s);
        wr_en    <= 1'b1;
        wr_index <= REG_EPS;
        wr_data  <= CFG_DATA_W'(s.eps);
        @(posedge clk);
        wr_index <= REG_DIM;
        wr_data  <= CFG_DATA_W'(s.dim);
        @(posedge clk);
        wr_index <= REG_NREW;
        wr_data  <= CFG_DATA_W'(s.nrew);
        @(posedge clk);
        wr_en    <= 1'b0;
        reg_eps  = s.eps;
        reg_dim  = s.dim;
        reg_nrew = s.nrew;
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_asked)
        begin
            hold_asked   = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // compare each accepted reward word with the oldest owed one
    always @(posedge clk)
    begin : reward_checker
        reward_word_t want;
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_rewards.size() == 0)
            begin
                $error("reward word with none owed: index %0d reward %0d",
                       rsp_ch.reward_index, rsp_ch.reward);
                mismatch_count++;
            end
            else
            begin
                want = awaited_rewards.pop_front();
                check_field("reward_index", want.index, rsp_ch.reward_index);
                check_field("reward", want.reward, rsp_ch.reward);
                check_field("last", want.last, rsp_ch.last);
                check_field("next_state_0", $signed(want.next_x[0]), rsp_ch.next_state_0);
                check_field("next_state_1", $signed(want.next_x[1]), rsp_ch.next_state_1);
                check_field("next_state_2", $signed(want.next_x[2]), rsp_ch.next_state_2);
                check_field("next_state_3", $signed(want.next_x[3]), rsp_ch.next_state_3);
            end
        end
    end

    // watchdog: too long with no word moving on either side
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        directed_row_t row;
        reward_word_t  typed_word;
        cmd_t          w;
        // every input known from time zero
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.operation   = OP_STEP;
        cmd_ch.component_0 = '0;
        cmd_ch.component_1 = '0;
        cmd_ch.component_2 = '0;
        cmd_ch.component_3 = '0;
        rsp_ch.ready       = 1'b0;
        wr_en              = 1'b0;
        wr_index           = REG_EPS;
        wr_data            = '0;
        // model at reset values
        reg_eps  = '0;
        reg_dim  = 3'd4;
        reg_nrew = 3'd1;
        for (int j = 0; j < NUM_COMP; j++)
            plant_x[j] = '0;
        set_flow(FLOW_FREE);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset settings
        foreach (DIRECTED_ROWS[k])
        begin
            row               = DIRECTED_ROWS[k];
            w.is_load         = row.op;
            w.comp            = row.comp;
            typed_word        = '0;
            typed_word.reward = row.reward;
            typed_word.last   = 1'b1;
            typed_word.next_x = row.next_x;
            send_command(w, row.typed, typed_word);
        end
        wait_for_rewards();

        // random phases, each under new register settings and a new flow mode
        foreach (PHASE_SETTINGS[p])
        begin
            apply_settings(PHASE_SETTINGS[p]);
            set_flow(flow_t'((p + 1) % 4));
            // free-flowing sender against a long receiver hold fills the block
            if (p == 3)
                hold_asked = 1'b1;
            repeat (RANDOM_PER_PHASE)
                send_command(random_command(), 1'b0, '0);
            wait_for_rewards();
        end

        // catch any stray reward word after the last owed one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_rewards.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
